// ===== hdl/bbp_pkg.sv =====
`default_nettype none

package bbp_pkg;

  // table sizes and step limit
  localparam int unsigned MaxAssetsDefault = 16;
  localparam int unsigned MaxStepsDefault  = 1024;

  // field widths
  localparam int unsigned AssetW  = 4;
  localparam int unsigned StepW   = 10;
  localparam int unsigned PriceW  = 32;
  localparam int unsigned WeightW = 16;
  localparam int unsigned StrikeW = 16;
  localparam int unsigned TStepsW = 11;
  localparam int unsigned ACountW = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned SumW    = 64;
  localparam int unsigned ProdW   = PriceW + 1 + WeightW;
  localparam int unsigned FracDrop = 12;
  localparam int unsigned StrikeShift = 28;
  localparam int unsigned InDataW = 128;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STRIKE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TSTEPS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACOUNT = 2'd2;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // one asset's table entry
  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [PriceW-1:0]  lower;
    logic [PriceW-1:0]  upper;
  } bbp_entry_t;

endpackage

`default_nettype wire

// ===== hdl/bbp_tables.sv =====
`default_nettype none

module bbp_tables #(
  parameter int unsigned MAX_ASSETS = bbp_pkg::MaxAssetsDefault
) (
  input  wire                                          clk_i,
  input  wire                                          we_i,
  input  wire  [(MAX_ASSETS > 1 ? $clog2(MAX_ASSETS) : 1)-1:0] waddr_i,
  input  bbp_pkg::bbp_entry_t                          wdata_i,
  input  wire                                          re_i,
  input  wire  [(MAX_ASSETS > 1 ? $clog2(MAX_ASSETS) : 1)-1:0] raddr_i,
  output bbp_pkg::bbp_entry_t                          rdata_o
);

  bbp_pkg::bbp_entry_t mem_q [MAX_ASSETS];
  bbp_pkg::bbp_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, updated only when a sample word for a used asset is taken
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/barrier_basket_payoff.sv =====
`default_nettype none

// Double-barrier basket call payoff over streamed Monte Carlo paths. Load words
// (tuser 0) write one asset's weight and barriers; sample words (tuser 1) are
// checked against their asset's barriers and, at the final time step, weighted
// and summed. A sample with tlast set emits one payoff word: max(sum - strike, 0)
// in Q16.16, saturated, or 0 with tuser set if the path was knocked out. The
// block takes one word per cycle while the output is drained; a result passes
// through the registered stages table read, multiply and barrier compare,
// accumulate, strike subtract and saturate. Unused assets' samples are dropped.
// The user writes configuration only while no word is in flight (not enforced).
module barrier_basket_payoff #(
  parameter int unsigned MAX_ASSETS = bbp_pkg::MaxAssetsDefault,
  parameter int unsigned MAX_STEPS  = bbp_pkg::MaxStepsDefault
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [bbp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire  [bbp_pkg::CfgW-1:0]           cfg_data_i,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // asset_index, step_index, price, weight, lower_bound, upper_bound, zero pad
  input  wire  [bbp_pkg::InDataW-1:0]        s_axis_tdata,
  // cmd
  input  wire                                s_axis_tuser,
  input  wire                                s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // payoff_value
  output logic [bbp_pkg::PriceW-1:0]         m_axis_tdata,
  // knocked_out
  output logic                               m_axis_tuser
);

  localparam int unsigned AW  = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
  localparam int unsigned IW  = 7;
  localparam int unsigned MSW = $clog2(MAX_STEPS + 1);
  localparam int unsigned SW  = (MSW > bbp_pkg::TStepsW) ? MSW : bbp_pkg::TStepsW;
  localparam logic [SW-1:0]  MaxStepsC  = SW'(MAX_STEPS);
  localparam logic [IW-1:0]  MaxAssetsC = IW'(MAX_ASSETS);
  localparam int unsigned SW64 = bbp_pkg::SumW;

  // configuration
  logic [bbp_pkg::StrikeW-1:0] strike_q;
  logic [bbp_pkg::TStepsW-1:0] tsteps_q;
  logic [bbp_pkg::ACountW-1:0] acount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strike_q <= '0;
      tsteps_q <= bbp_pkg::TStepsW'(1);
      acount_q <= bbp_pkg::ACountW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbp_pkg::CFG_STRIKE: strike_q <= cfg_data_i[bbp_pkg::StrikeW-1:0];
        bbp_pkg::CFG_TSTEPS: tsteps_q <= cfg_data_i[bbp_pkg::TStepsW-1:0];
        bbp_pkg::CFG_ACOUNT: acount_q <= cfg_data_i[bbp_pkg::ACountW-1:0];
        default: ;
      endcase
    end
  end

  // input word unpack
  logic [bbp_pkg::AssetW-1:0]  in_asset;
  logic [bbp_pkg::StepW-1:0]   in_step;
  logic [bbp_pkg::PriceW-1:0]  in_price;
  bbp_pkg::bbp_entry_t         in_entry;

  assign in_asset        = s_axis_tdata[3:0];
  assign in_step         = s_axis_tdata[13:4];
  assign in_price        = s_axis_tdata[45:14];
  assign in_entry.weight = s_axis_tdata[61:46];
  assign in_entry.lower  = s_axis_tdata[93:62];
  assign in_entry.upper  = s_axis_tdata[125:94];

  logic            in_take;
  logic [IW-1:0]   asset_ext;
  logic            asset_in_tbl;
  logic            asset_used;
  logic [SW-1:0]   steps_eff;
  logic [SW-1:0]   step_ext;
  logic            step_ok;
  logic            step_final;
  logic            load_we;
  logic            sample_go;

  assign in_take      = s_axis_tvalid && s_axis_tready;
  assign asset_ext    = IW'(in_asset);
  assign asset_in_tbl = asset_ext < MaxAssetsC;
  assign asset_used   = asset_in_tbl && (asset_ext < IW'(acount_q));
  assign steps_eff    = (SW'(tsteps_q) < MaxStepsC) ? SW'(tsteps_q) : MaxStepsC;
  assign step_ext     = SW'(in_step);
  assign step_ok      = step_ext < steps_eff;
  assign step_final   = (step_ext + SW'(1)) == steps_eff;
  assign load_we      = in_take && (s_axis_tuser == bbp_pkg::CMD_LOAD) && asset_in_tbl;
  assign sample_go    = in_take && (s_axis_tuser == bbp_pkg::CMD_SAMPLE) && asset_used;

  bbp_pkg::bbp_entry_t tbl_rd;

  bbp_tables #(
    .MAX_ASSETS (MAX_ASSETS)
  ) u_tables (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (asset_ext[AW-1:0]),
    .wdata_i (in_entry),
    .re_i    (sample_go),
    .raddr_i (asset_ext[AW-1:0]),
    .rdata_o (tbl_rd)
  );

  // handshake chain: each stage moves when the next has room
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_ok_q, s1_fin_q, s1_last_q;
  logic [bbp_pkg::PriceW-1:0] s1_price_q;
  logic s2_acc_q, s2_brk_q, s2_last_q;
  logic signed [bbp_pkg::ProdW-1:0] s2_prod_q;

  logic out_free, s3_free, s2_adv, s2_free, s1_adv, s1_free;

  assign out_free = !out_v_q || m_axis_tready;
  assign s3_free  = !s3_v_q || out_free;
  assign s2_adv   = s2_v_q && (!s2_last_q || s3_free);
  assign s2_free  = !s2_v_q || s2_adv;
  assign s1_adv   = s1_v_q && s2_free;
  assign s1_free  = !s1_v_q || s1_adv;
  assign s_axis_tready = s1_free;

  // stage 1: sample word and its table entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= sample_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_go) begin
      s1_ok_q    <= step_ok;
      s1_fin_q   <= step_ok && step_final;
      s1_last_q  <= s_axis_tlast;
      s1_price_q <= in_price;
    end
  end

  // stage 2: barrier compare and weighting
  logic signed [bbp_pkg::ProdW-1:0] prod;
  logic                             breach;

  assign prod   = $signed({1'b0, s1_price_q}) * $signed(tbl_rd.weight);
  assign breach = s1_ok_q && ((s1_price_q < tbl_rd.lower) || (s1_price_q > tbl_rd.upper));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_prod_q <= prod;
      s2_acc_q  <= s1_fin_q;
      s2_brk_q  <= breach;
      s2_last_q <= s1_last_q;
    end
  end

  // stage 3: path accumulator, handed off on the path's last sample
  logic [SW64-1:0] sum_q;
  logic            brk_q;
  logic [SW64-1:0] sum_d;
  logic            brk_d;
  logic [SW64-1:0] res_sum_q;
  logic            res_brk_q;

  assign sum_d = sum_q + (s2_acc_q ? SW64'(s2_prod_q) : '0);
  assign brk_d = brk_q || s2_brk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      brk_q  <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s2_adv) begin
        if (s2_last_q) begin
          sum_q <= '0;
          brk_q <= 1'b0;
        end else begin
          sum_q <= sum_d;
          brk_q <= brk_d;
        end
      end
      if (s2_adv && s2_last_q) begin
        s3_v_q <= 1'b1;
      end else if (out_free) begin
        s3_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s2_last_q) begin
      res_sum_q <= sum_d;
      res_brk_q <= brk_d;
    end
  end

  // output stage: strike subtract, truncate to Q16.16, saturate
  logic [SW64-1:0]             diff;
  logic                        in_money;
  logic                        sat;
  logic [bbp_pkg::PriceW-1:0]  payoff;
  logic [bbp_pkg::PriceW-1:0]  out_data_q;
  logic                        out_ko_q;

  assign diff     = res_sum_q - (SW64'(strike_q) << bbp_pkg::StrikeShift);
  assign in_money = !res_brk_q && (diff != '0) && !diff[SW64-1];
  assign sat      = |diff[SW64-2:bbp_pkg::PriceW+bbp_pkg::FracDrop];
  assign payoff   = !in_money ? '0 :
                    sat ? '1 : diff[bbp_pkg::PriceW+bbp_pkg::FracDrop-1:bbp_pkg::FracDrop];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s3_v_q) begin
      out_data_q <= payoff;
      out_ko_q   <= res_brk_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ko_q;

  // a knocked-out path never pays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("knocked-out word with non-zero payoff");

  // a pending result is kept until the output stage takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && !out_free) |=> (s3_v_q && $stable(res_sum_q) && $stable(res_brk_q)))
    else $error("pending result lost");

  // the accumulator restarts after every path end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_adv && s2_last_q) |=> ((sum_q == '0) && !brk_q))
    else $error("accumulator not cleared at path end");

endmodule

`default_nettype wire

// ===== verif/barrier_basket_payoff_tb.sv =====
`timescale 1ns / 1ps

module barrier_basket_payoff_tb;
  import bbp_pkg::*;

  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned HoldCycles = 400;

  typedef struct {
    logic                 cmd;
    logic [AssetW-1:0]    asset;
    logic [StepW-1:0]     step;
    logic [PriceW-1:0]    price;
    logic [WeightW-1:0]   weight;
    logic [PriceW-1:0]    lower;
    logic [PriceW-1:0]    upper;
    logic                 last;
  } word_t;

  typedef struct {
    logic [PriceW-1:0] payoff;
    logic              knocked;
  } payoff_t;

  typedef struct {
    word_t   w;
    bit      typed;
    payoff_t res;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = CFG_STRIKE;
  logic [CfgW-1:0]      cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // asset_index, step_index, price, weight, lower_bound, upper_bound, zero pad
  logic [InDataW-1:0]   s_axis_tdata = '0;
  // cmd
  logic                 s_axis_tuser = CMD_LOAD;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // payoff_value
  logic [PriceW-1:0]    m_axis_tdata;
  // knocked_out
  logic                 m_axis_tuser;

  // predictor state
  logic [WeightW-1:0]   wt_tab [MaxAssetsDefault];
  logic [PriceW-1:0]    lo_tab [MaxAssetsDefault];
  logic [PriceW-1:0]    hi_tab [MaxAssetsDefault];
  logic [SumW-1:0]      basket_acc = '0;
  logic                 breach_seen = 1'b0;
  logic [StrikeW-1:0]   cfg_strike = '0;
  logic [TStepsW-1:0]   cfg_tsteps = 1;
  logic [ACountW-1:0]   cfg_acount = 1;

  payoff_t              payoff_q [$];
  payoff_t              no_res = '{payoff: '0, knocked: 1'b0};
  dir_row_t             dir_tab [$];
  int unsigned          words_taken = 0;
  int unsigned          err_cnt = 0;
  int unsigned          cycle_cnt = 0;
  int unsigned          tx_pct = 0;
  int unsigned          rx_pct = 0;
  bit                   hold_go = 1'b0;
  bit                   hold_used = 1'b0;
  int unsigned          hold_left = 0;

  barrier_basket_payoff u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // advances the path state by one word, returns 1 when the word closes a path
  function automatic bit apply_basket_word(input word_t w, output payoff_t r);
    logic [SumW-1:0] prod;
    logic [SumW-1:0] diff;
    logic [SumW-1:0] q;
    logic [WeightW-1:0] wt;
    int unsigned eff;
    r = no_res;
    if (w.cmd == CMD_LOAD) begin
      wt_tab[w.asset] = w.weight;
      lo_tab[w.asset] = w.lower;
      hi_tab[w.asset] = w.upper;
      return 1'b0;
    end
    if (w.asset >= cfg_acount) return 1'b0;
    eff = (cfg_tsteps < MaxStepsDefault) ? cfg_tsteps : MaxStepsDefault;
    if (w.step < eff) begin
      if (w.price < lo_tab[w.asset] || w.price > hi_tab[w.asset]) breach_seen = 1'b1;
      if (w.step + 1 == eff) begin
        wt = wt_tab[w.asset];
        prod = $signed({32'd0, w.price}) * $signed({{48{wt[WeightW-1]}}, wt});
        basket_acc = basket_acc + prod;
      end
    end
    if (!w.last) return 1'b0;
    diff = basket_acc - ({48'd0, cfg_strike} << StrikeShift);
    q = '0;
    if (!breach_seen && diff != 0 && !diff[SumW-1]) begin
      q = diff >> FracDrop;
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    end
    r.payoff  = q[PriceW-1:0];
    r.knocked = breach_seen;
    basket_acc  = '0;
    breach_seen = 1'b0;
    return 1'b1;
  endfunction

  function automatic word_t load_word(input logic [AssetW-1:0] a, input logic [WeightW-1:0] wt,
                                      input logic [PriceW-1:0] lo, input logic [PriceW-1:0] hi);
    word_t w;
    w = '{cmd: CMD_LOAD, asset: a, step: '0, price: '0, weight: wt, lower: lo, upper: hi,
          last: 1'b0};
    return w;
  endfunction

  function automatic word_t sample_word(input logic [AssetW-1:0] a, input logic [StepW-1:0] st,
                                        input logic [PriceW-1:0] pr, input logic lst);
    word_t w;
    w = '{cmd: CMD_SAMPLE, asset: a, step: st, price: pr, weight: '0, lower: '0, upper: '0,
          last: lst};
    return w;
  endfunction

  function automatic dir_row_t ld_row(input logic [AssetW-1:0] a, input logic [WeightW-1:0] wt,
                                      input logic [PriceW-1:0] lo, input logic [PriceW-1:0] hi);
    dir_row_t row;
    row.w = load_word(a, wt, lo, hi);
    row.typed = 1'b0;
    row.res = no_res;
    return row;
  endfunction

  function automatic dir_row_t smp_row(input logic [AssetW-1:0] a, input logic [StepW-1:0] st,
                                       input logic [PriceW-1:0] pr, input logic lst,
                                       input bit typed, input logic [PriceW-1:0] pay,
                                       input logic ko);
    dir_row_t row;
    row.w = sample_word(a, st, pr, lst);
    row.typed = typed;
    row.res = '{payoff: pay, knocked: ko};
    return row;
  endfunction

  // weight of random magnitude and a barrier band scaled to match
  function automatic word_t band_load(input logic [AssetW-1:0] a);
    logic [WeightW-1:0] wt;
    logic [PriceW-1:0] lo;
    int unsigned sh;
    sh = $urandom_range(0, 16);
    wt = WeightW'($signed(WeightW'($urandom())) >>> $urandom_range(0, 12));
    lo = $urandom_range(0, 32'h4000_0000) >> sh;
    return load_word(a, wt, lo, lo + ($urandom_range(32'h4000_0000, 32'hBFFF_FFFF) >> sh));
  endfunction

  function automatic logic [PriceW-1:0] pick_price(input logic [AssetW-1:0] a);
    if (hi_tab[a] >= lo_tab[a] && $urandom_range(0, 19) != 0)
      return lo_tab[a] + $urandom_range(0, hi_tab[a] - lo_tab[a]);
    return $urandom();
  endfunction

  task automatic drive_word(input word_t w, input bit typed, input payoff_t fixed);
    payoff_t r;
    while (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({w.upper, w.lower, w.weight, w.price, w.step, w.asset});
    s_axis_tuser  <= w.cmd;
    s_axis_tlast  <= w.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!(w.cmd == CMD_SAMPLE && w.asset >= cfg_acount)) words_taken++;
    if (apply_basket_word(w, r)) begin
      if (typed) r = fixed;
      payoff_q.push_back(r);
    end
  endtask

  task automatic wait_drained();
    while (payoff_q.size() != 0) @(posedge clk_i);
    // loads and dropped samples leave no result behind them
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_STRIKE: cfg_strike = val[StrikeW-1:0];
      CFG_TSTEPS: cfg_tsteps = val[TStepsW-1:0];
      CFG_ACOUNT: cfg_acount = val[ACountW-1:0];
      default: ;
    endcase
  endtask

  // one path: up to two random steps, then the final step, time-major
  task automatic send_path();
    word_t w;
    int unsigned eff_steps, n_assets, n_mid, st, rot;
    bit broken;
    eff_steps = (cfg_tsteps < MaxStepsDefault) ? cfg_tsteps : MaxStepsDefault;
    n_assets = (cfg_acount < MaxAssetsDefault) ? cfg_acount : MaxAssetsDefault;
    if (n_assets == 0) begin
      drive_word(sample_word($urandom_range(0, 15), $urandom_range(0, 1023), $urandom(), 1'b1),
                 1'b0, no_res);
      return;
    end
    broken = ($urandom_range(0, 19) == 0);
    n_mid = $urandom_range(0, 2);
    rot = $urandom_range(0, 15);
    for (int k = 0; k <= n_mid; k++) begin
      if (eff_steps == 0) st = $urandom_range(0, 1023);
      else if (k == n_mid) st = eff_steps - 1;
      else if (eff_steps < MaxStepsDefault && $urandom_range(0, 7) == 0)
        st = $urandom_range(eff_steps, 1023);
      else st = $urandom_range(0, eff_steps - 1);
      for (int j = 0; j < n_assets; j++) begin
        w = sample_word((j + rot) % n_assets, st, 1'b0, (k == n_mid && j == n_assets - 1));
        w.price = pick_price(w.asset);
        // broken path: early end or missing end, sums run into the next path
        if (broken && $urandom_range(0, 3) == 0) w.last = ~w.last;
        drive_word(w, 1'b0, no_res);
      end
    end
  endtask

  task automatic run_phase(input int unsigned p);
    logic [CfgW-1:0] strike_v, tsteps_v, acount_v;
    int unsigned budget, first, iter, n_assets, n_loads;
    word_t w;
    case (p)
      0: begin strike_v = 0;     tsteps_v = 1;    acount_v = 1;  end
      1: begin strike_v = 65535; tsteps_v = 1024; acount_v = 16; end
      2: begin strike_v = 300;   tsteps_v = 3;    acount_v = 4;  end
      3: begin
        strike_v = $urandom_range(0, 65535);
        tsteps_v = $urandom_range(1, 6);
        acount_v = $urandom_range(1, 16);
      end
      4: begin strike_v = 0;     tsteps_v = 0;    acount_v = 16; end
      5: begin strike_v = 12;    tsteps_v = 2047; acount_v = 31; end
      6: begin strike_v = $urandom_range(0, 65535); tsteps_v = 2; acount_v = 0; end
      default: begin
        strike_v = $urandom_range(0, 65535) >> $urandom_range(0, 16);
        tsteps_v = (p == 11) ? 1024 : $urandom_range(1, 5);
        acount_v = $urandom_range(1, 4);
      end
    endcase
    wait_drained();
    case (p % 4)
      0: begin tx_pct = 0;  rx_pct = 0;  end
      1: begin tx_pct = 77; rx_pct = 0;  end
      2: begin tx_pct = 0;  rx_pct = 77; end
      default: begin tx_pct = 32; rx_pct = 32; end
    endcase
    write_reg(CFG_STRIKE, strike_v);
    write_reg(CFG_TSTEPS, tsteps_v);
    write_reg(CFG_ACOUNT, acount_v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_assets = (cfg_acount < MaxAssetsDefault) ? cfg_acount : MaxAssetsDefault;
    n_loads = (p == 0) ? MaxAssetsDefault : n_assets;
    for (int a = 0; a < n_loads; a++) drive_word(band_load(a), 1'b0, no_res);
    // long output stall with the sender still pushing
    if (p == 2) hold_go = 1'b1;
    budget = (p == 4 || p == 6) ? 40 : 125;
    first = words_taken;
    iter = 0;
    while (words_taken - first < budget && iter < 300) begin
      iter++;
      if ($urandom_range(0, 9) == 0) begin
        w.cmd    = $urandom_range(0, 1) ? CMD_SAMPLE : CMD_LOAD;
        w.asset  = $urandom_range(0, 15);
        w.step   = $urandom_range(0, 1023);
        w.price  = $urandom();
        w.weight = $urandom_range(0, 16'hFFFF);
        w.lower  = $urandom();
        w.upper  = $urandom();
        w.last   = ($urandom_range(0, 3) == 0);
        if (w.cmd == CMD_LOAD && $urandom_range(0, 1) == 1) w = band_load(w.asset);
        drive_word(w, 1'b0, no_res);
      end else begin
        send_path();
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_pct);
    end
  end

  always @(posedge clk_i) begin : payoff_chk
    payoff_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (payoff_q.size() == 0) begin
        $error("unexpected payoff word: payoff_value %h knocked_out %b",
               m_axis_tdata, m_axis_tuser);
        err_cnt++;
      end else begin
        want = payoff_q.pop_front();
        if (m_axis_tdata !== want.payoff) begin
          $error("payoff_value: expected %h, got %h", want.payoff, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tuser !== want.knocked) begin
          $error("knocked_out: expected %b, got %b", want.knocked, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    // default setting after reset: strike 0, one step, one asset
    dir_tab.push_back(ld_row(0, 16'h1000, 32'h0, 32'hFFFF_FFFF));
    dir_tab.push_back(smp_row(0, 0, 32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000, 1'b0));
    dir_tab.push_back(smp_row(0, 0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0));
    dir_tab.push_back(smp_row(0, 0, 32'h0, 1'b1, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(ld_row(0, 16'h7FFF, 32'h0, 32'hFFFF_FFFF));
    // saturates
    dir_tab.push_back(smp_row(0, 0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0));
    dir_tab.push_back(ld_row(0, 16'h8000, 32'h0, 32'hFFFF_FFFF));
    dir_tab.push_back(smp_row(0, 0, 32'h0001_0000, 1'b1, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(ld_row(0, 16'h1000, 32'h0002_0000, 32'h0003_0000));
    dir_tab.push_back(smp_row(0, 0, 32'h0001_0000, 1'b1, 1'b1, 32'h0, 1'b1));
    dir_tab.push_back(smp_row(0, 0, 32'h0004_0000, 1'b1, 1'b1, 32'h0, 1'b1));
    // barriers themselves are inside the band
    dir_tab.push_back(smp_row(0, 0, 32'h0002_0000, 1'b1, 1'b1, 32'h0002_0000, 1'b0));
    dir_tab.push_back(smp_row(0, 0, 32'h0003_0000, 1'b1, 1'b1, 32'h0003_0000, 1'b0));
    // breach mid-path sticks until the path ends
    dir_tab.push_back(smp_row(0, 0, 32'h0001_0000, 1'b0, 1'b0, 32'h0, 1'b0));
    dir_tab.push_back(smp_row(0, 0, 32'h0002_8000, 1'b1, 1'b1, 32'h0, 1'b1));
    // unused assets are dropped, end flag included
    dir_tab.push_back(smp_row(1, 0, 32'h0002_8000, 1'b1, 1'b0, 32'h0, 1'b0));
    dir_tab.push_back(smp_row(15, 0, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0));
    // step past the end: no barrier check, end flag still honoured
    dir_tab.push_back(smp_row(0, 1, 32'h0, 1'b1, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(smp_row(0, 10'h3FF, 32'h0, 1'b1, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(ld_row(15, 16'hFFFF, 32'hFFFF_FFFF, 32'h0));
    dir_tab.push_back(ld_row(0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF));
    dir_tab.push_back(smp_row(0, 0, 32'h0000_1000, 1'b1, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(ld_row(0, 16'h0001, 32'h0, 32'hFFFF_FFFF));
    dir_tab.push_back(smp_row(0, 0, 32'h0000_1000, 1'b1, 1'b1, 32'h1, 1'b0));
    // fraction below one lsb truncates to zero
    dir_tab.push_back(smp_row(0, 0, 32'h0000_0FFF, 1'b1, 1'b1, 32'h0, 1'b0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) drive_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);
    s_axis_tvalid <= 1'b0;
    for (int p = 0; p < 12; p++) run_phase(p);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bbp_pkg.sv
hdl/bbp_tables.sv
hdl/barrier_basket_payoff.sv
verif/barrier_basket_payoff_tb.sv
